// ===== hw/rtl/cpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpf_pkg: shared types and constants of the command packet framer
// Packet types, result roles, status codes and the state and result records.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam int unsigned WordWidth   = 32;
  localparam int unsigned CountWidth  = 14;
  localparam int unsigned LeftWidth   = 15;
  localparam int unsigned OpcodeWidth = 8;
  localparam int unsigned RoleWidth   = 3;
  localparam int unsigned StatusWidth = 3;

  // Header field positions
  localparam int unsigned TypeMsb   = 31;
  localparam int unsigned TypeLsb   = 30;
  localparam int unsigned OpcodeMsb = 23;
  localparam int unsigned OpcodeLsb = 16;

  // Packet type codes in the top two bits of a header
  localparam logic [1:0] TYPE_ZERO   = 2'd0;
  localparam logic [1:0] TYPE_UNSUP  = 2'd1;
  localparam logic [1:0] TYPE_FILLER = 2'd2;
  localparam logic [1:0] TYPE_THREE  = 2'd3;

  typedef enum logic [RoleWidth-1:0] {
    ROLE_FILLER  = 3'd0,
    ROLE_T0      = 3'd1,
    ROLE_T3      = 3'd2,
    ROLE_PAYLOAD = 3'd3,
    ROLE_DISCARD = 3'd4
  } role_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_BUSY   = 3'd0,
    ST_DONE   = 3'd1,
    ST_TRUNC0 = 3'd2,
    ST_TRUNC3 = 3'd3,
    ST_UNSUP  = 3'd4
  } status_e;

  // Framing state carried from word to word
  typedef struct packed {
    logic [LeftWidth-1:0]   words_left;
    logic [CountWidth-1:0]  payload_pos;
    logic                   open_is3;
    logic [OpcodeWidth-1:0] open_opcode;
    logic                   error_seen;
  } frame_state_t;

  // One result item
  typedef struct packed {
    role_e                  role;
    logic [OpcodeWidth-1:0] opcode;
    logic [WordWidth-1:0]   data;
    logic [CountWidth-1:0]  payload_index;
    logic                   packet_last;
    status_e                status;
  } frame_result_t;

endpackage

// ===== hw/rtl/cpf_in_if.sv =====
// ----------------------------------------------------------------------------
// cpf_in_if: command word channel
// Valid/ready channel carrying one command word and its buffer-end flag.
// ----------------------------------------------------------------------------
interface cpf_in_if import cpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] word;
  logic                 buffer_end;

  modport source (output valid, output word, output buffer_end, input ready);
  modport sink   (input valid, input word, input buffer_end, output ready);
endinterface

// ===== hw/rtl/cpf_out_if.sv =====
// ----------------------------------------------------------------------------
// cpf_out_if: framed word channel
// Valid/ready channel carrying one framed word with its role and status.
// ----------------------------------------------------------------------------
interface cpf_out_if import cpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RoleWidth-1:0]   role;
  logic [OpcodeWidth-1:0] opcode;
  logic [WordWidth-1:0]   data;
  logic [CountWidth-1:0]  payload_index;
  logic                   packet_last;
  logic [StatusWidth-1:0] status;

  modport source (output valid, output role, output opcode, output data,
                  output payload_index, output packet_last, output status,
                  input ready);
  modport sink   (input valid, input role, input opcode, input data,
                  input payload_index, input packet_last, input status,
                  output ready);
endinterface

// ===== hw/rtl/cpf_decode.sv =====
// ----------------------------------------------------------------------------
// cpf_decode: per-word framing step
// Classifies one word against the current framing state and gives the
// result item and the state to hold for the next word.
// ----------------------------------------------------------------------------
module cpf_decode import cpf_pkg::*; (
  input  logic [WordWidth-1:0] word_i,
  input  logic                 buffer_end_i,
  input  frame_state_t         state_i,
  output frame_state_t         state_o,
  output frame_result_t        result_o
);

  logic [LeftWidth-1:0] left_dec;
  logic [LeftWidth-1:0] count;
  logic [1:0]           hdr_type;

  assign left_dec = state_i.words_left - LeftWidth'(1);
  assign count    = {1'b0, word_i[CountWidth-1:0]} + LeftWidth'(1);
  assign hdr_type = word_i[TypeMsb:TypeLsb];

  always_comb begin
    state_o                = state_i;
    result_o.role          = ROLE_DISCARD;
    result_o.opcode        = '0;
    result_o.data          = word_i;
    result_o.payload_index = '0;
    result_o.packet_last   = 1'b0;
    result_o.status        = ST_BUSY;

    if (state_i.error_seen) begin
      // discard until the buffer ends
      result_o.role = ROLE_DISCARD;
    end else if (state_i.words_left != '0) begin
      // payload word of the open packet
      result_o.role          = ROLE_PAYLOAD;
      result_o.opcode        = state_i.open_is3 ? state_i.open_opcode : '0;
      result_o.payload_index = state_i.payload_pos;
      state_o.words_left     = left_dec;
      state_o.payload_pos    = state_i.payload_pos + CountWidth'(1);
      if (left_dec == '0) begin
        result_o.packet_last = 1'b1;
        if (buffer_end_i) result_o.status = ST_DONE;
      end else if (buffer_end_i) begin
        result_o.status = state_i.open_is3 ? ST_TRUNC3 : ST_TRUNC0;
      end
    end else begin
      // header word
      case (hdr_type)
        TYPE_FILLER: begin
          result_o.role        = ROLE_FILLER;
          result_o.packet_last = 1'b1;
          if (buffer_end_i) result_o.status = ST_DONE;
        end
        TYPE_ZERO: begin
          result_o.role       = ROLE_T0;
          state_o.open_is3    = 1'b0;
          state_o.open_opcode = '0;
          state_o.words_left  = count;
          state_o.payload_pos = '0;
          if (buffer_end_i) result_o.status = ST_TRUNC0;
        end
        TYPE_THREE: begin
          result_o.role       = ROLE_T3;
          result_o.opcode     = word_i[OpcodeMsb:OpcodeLsb];
          state_o.open_is3    = 1'b1;
          state_o.open_opcode = word_i[OpcodeMsb:OpcodeLsb];
          state_o.words_left  = count;
          state_o.payload_pos = '0;
          if (buffer_end_i) result_o.status = ST_TRUNC3;
        end
        default: begin
          result_o.role      = ROLE_DISCARD;
          result_o.status    = ST_UNSUP;
          state_o.error_seen = 1'b1;
        end
      endcase
    end

    // drop all framing state at the end of every buffer
    if (buffer_end_i) state_o = '0;
  end

endmodule

// ===== hw/rtl/command_packet_framer.sv =====
// ----------------------------------------------------------------------------
// command_packet_framer: frames command words into packets
// Tags every command word with its packet role, opcode, payload index and
// buffer status; one result per input word.
// ----------------------------------------------------------------------------
// Channel   Dir  Modport  Payload
// in_i      in   sink     word[31:0], buffer_end
// out_o     out  source   role[2:0], opcode[7:0], data[31:0],
//                         payload_index[13:0], packet_last, status[2:0]
//
// One word per cycle sustained while out_o does not stall; a word's result
// passes the input register, then the result register, before it can
// transfer on out_o. Framing state advances when the registered word
// moves to the result register, so stalls on out_o hold the state and
// back up in_i. Reset clears the framing state and both valid flags;
// no clearing pass.
// ----------------------------------------------------------------------------
module command_packet_framer import cpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpf_in_if.sink    in_i,
  cpf_out_if.source out_o
);

  logic                 in_valid_q;
  logic [WordWidth-1:0] word_q;
  logic                 end_q;
  frame_state_t         state_q, state_d;
  frame_result_t        result_d, result_q;
  logic                 out_valid_q;
  logic                 advance;

  // move the registered word on when the result slot is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  cpf_decode u_decode (
    .word_i       (word_q),
    .buffer_end_i (end_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture the input transfer and the result
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      word_q <= in_i.word;
      end_q  <= in_i.buffer_end;
    end
    if (advance) result_q <= result_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.role          = result_q.role;
  assign out_o.opcode        = result_q.opcode;
  assign out_o.data          = result_q.data;
  assign out_o.payload_index = result_q.payload_index;
  assign out_o.packet_last   = result_q.packet_last;
  assign out_o.status        = result_q.status;

endmodule

// ===== tb/cpf_framer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpf_framer_checker: result predictor and scoreboard for the packet framer
// Watches both channels, frames every accepted command word with its own copy
// of the framing state and compares each framed result in order, field by
// field. Reports the mismatch count, the results outstanding and what ran.
// ----------------------------------------------------------------------------
module cpf_framer_checker import cpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpf_in_if           in_i,
  cpf_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned backlog_o,
  output int unsigned checked_o,
  output int unsigned errored_o
);

  // Framing state of the predictor
  logic [LeftWidth-1:0]   owed_words;
  logic [CountWidth-1:0]  next_index;
  logic                   open_is3;
  logic [OpcodeWidth-1:0] open_opcode;
  logic                   discarding;

  frame_result_t framed_q[$];
  int unsigned   fails;
  int unsigned   checked;
  int unsigned   errored;

  // Return the framing state to its idle values
  function automatic void clear_framing();
    owed_words  = '0;
    next_index  = '0;
    open_is3    = 1'b0;
    open_opcode = '0;
    discarding  = 1'b0;
  endfunction

  // Frame one command word and advance the framing state
  function automatic frame_result_t frame_word(input logic [WordWidth-1:0] w,
                                               input logic ends_buf);
    frame_result_t r;
    logic [1:0]    kind;
    r.role          = ROLE_DISCARD;
    r.opcode        = '0;
    r.data          = w;
    r.payload_index = '0;
    r.packet_last   = 1'b0;
    r.status        = ST_BUSY;
    kind            = w[TypeMsb:TypeLsb];

    if (discarding) begin
      // drop everything up to the end of the buffer
    end else if (owed_words != '0) begin
      r.role          = ROLE_PAYLOAD;
      r.opcode        = open_is3 ? open_opcode : '0;
      r.payload_index = next_index;
      owed_words      = owed_words - 1'b1;
      next_index      = next_index + 1'b1;
      if (owed_words == '0) begin
        r.packet_last = 1'b1;
        if (ends_buf) r.status = ST_DONE;
      end else if (ends_buf) begin
        r.status = open_is3 ? ST_TRUNC3 : ST_TRUNC0;
      end
    end else if (kind == TYPE_FILLER) begin
      r.role        = ROLE_FILLER;
      r.packet_last = 1'b1;
      if (ends_buf) r.status = ST_DONE;
    end else if (kind == TYPE_ZERO || kind == TYPE_THREE) begin
      open_is3    = (kind == TYPE_THREE);
      r.role      = open_is3 ? ROLE_T3 : ROLE_T0;
      r.opcode    = open_is3 ? w[OpcodeMsb:OpcodeLsb] : '0;
      open_opcode = r.opcode;
      owed_words  = LeftWidth'(w[CountWidth-1:0]) + 1'b1;
      next_index  = '0;
      if (ends_buf) r.status = open_is3 ? ST_TRUNC3 : ST_TRUNC0;
    end else begin
      r.status   = ST_UNSUP;
      discarding = 1'b1;
    end

    if (ends_buf) clear_framing();
    return r;
  endfunction

  // Report one field that differs from its prediction
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Predict on every input transfer, compare on every result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      clear_framing();
      framed_q.delete();
      fails   = 0;
      checked = 0;
      errored = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        want = frame_word(in_i.word, in_i.buffer_end);
        if (want.status inside {ST_TRUNC0, ST_TRUNC3, ST_UNSUP}) errored++;
        framed_q.insert(framed_q.size(), want);
      end
      if (out_i.valid && out_i.ready) begin
        if (framed_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, actual data %0h role %0d",
                   $time, out_i.data, out_i.role);
        end else begin
          want = framed_q.pop_front();
          checked++;
          check_field("role", 32'(want.role), 32'(out_i.role));
          check_field("opcode", 32'(want.opcode), 32'(out_i.opcode));
          check_field("data", want.data, out_i.data);
          check_field("payload_index", 32'(want.payload_index), 32'(out_i.payload_index));
          check_field("packet_last", 32'(want.packet_last), 32'(out_i.packet_last));
          check_field("status", 32'(want.status), 32'(out_i.status));
        end
      end
    end
    fail_count_o <= fails;
    backlog_o    <= framed_q.size();
    checked_o    <= checked;
    errored_o    <= errored;
  end

endmodule

// ===== tb/command_packet_framer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_packet_framer_tb: top level of the packet framer testbench
// Drives command buffers into the framer with random gaps and output stalls:
// a directed set of headers, payloads, truncations and unsupported types,
// then random buffers, mostly well formed, some cut short, some broken by an
// unsupported header and some pure noise. The checker scores every result.
// ----------------------------------------------------------------------------
module command_packet_framer_tb import cpf_pkg::*; ();

  localparam int unsigned RandomWords = 1650;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady = 1'b0;

  int unsigned fails;
  int unsigned backlog;
  int unsigned checked;
  int unsigned errored;
  int unsigned words_sent = 0;
  int unsigned buffers_sent = 0;

  logic [WordWidth-1:0] burst[$];

  cpf_in_if  in_ch ();
  cpf_out_if out_ch ();

  command_packet_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cpf_framer_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fails),
    .backlog_o    (backlog),
    .checked_o    (checked),
    .errored_o    (errored)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result channel at random unless in a steady stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= steady || ($urandom_range(99) >= 26);
    end
  end

  // Offer one command word, with random gaps, and hold it until transferred
  task automatic send_word(input logic [WordWidth-1:0] w, input logic ends_buf);
    while (!steady && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.word       <= w;
    in_ch.buffer_end <= ends_buf;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
    if (ends_buf) buffers_sent++;
  endtask

  // Send the queued buffer, marking its last word
  task automatic send_burst();
    int unsigned n;
    n = burst.size();
    for (int unsigned i = 0; i < n; i++) send_word(burst[i], i == n - 1);
  endtask

  // Header of the given type with random filler bits and the given count
  function automatic logic [WordWidth-1:0] make_header(input logic [1:0] kind,
                                                       input int unsigned count);
    logic [WordWidth-1:0] w;
    w                     = $urandom();
    w[TypeMsb:TypeLsb]    = kind;
    w[CountWidth-1:0]     = CountWidth'(count);
    return w;
  endfunction

  // Mostly short packets, now and then a longer one
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 90) return $urandom_range(7, 0);
    if (r < 99) return $urandom_range(63, 8);
    return $urandom_range(300, 64);
  endfunction

  // Fill the burst queue with one random buffer
  task automatic build_buffer();
    int unsigned mode;
    int unsigned packets;
    int          bad_at;
    int unsigned count;
    int unsigned kind_pick;
    int unsigned keep;
    burst.delete();
    mode = $urandom_range(99);
    if (mode >= 94) begin
      // pure noise
      repeat ($urandom_range(6, 1)) burst.insert(burst.size(), $urandom());
      return;
    end
    packets = $urandom_range(6, 1);
    bad_at  = (mode >= 82) ? int'($urandom_range(packets - 1, 0)) : -1;
    for (int p = 0; p < packets; p++) begin
      if (p == bad_at) begin
        burst.insert(burst.size(), make_header(TYPE_UNSUP, $urandom_range(16383, 0)));
        repeat ($urandom_range(3, 0)) burst.insert(burst.size(), $urandom());
      end
      kind_pick = $urandom_range(2, 0);
      if (kind_pick == 0) begin
        burst.insert(burst.size(), make_header(TYPE_FILLER, $urandom_range(16383, 0)));
      end else begin
        count = pick_count();
        burst.insert(burst.size(),
                     make_header(kind_pick == 1 ? TYPE_ZERO : TYPE_THREE, count));
        repeat (count + 1) burst.insert(burst.size(), $urandom());
      end
    end
    // cut short to end the buffer inside a packet
    if (mode >= 70 && mode < 82 && burst.size() > 1) begin
      keep = $urandom_range(burst.size() - 1, 1);
      while (burst.size() > keep) void'(burst.pop_back());
    end
  endtask

  initial begin
    int unsigned random_words;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.word       = '0;
    in_ch.buffer_end = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Clean buffer: fillers, a type 0 and a type 3 packet
    send_word(32'h8000_0000, 1'b0);
    send_word(32'hBFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hC0AB_0001, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h9ABC_DEF0, 1'b1);
    // Unsupported header, then discarded words to the end of the buffer
    send_word(32'h4000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'hC000_0000, 1'b1);
    // Unsupported header that also ends its buffer
    send_word(32'h7FFF_FFFF, 1'b1);
    // Headers that end the buffer, largest count
    send_word(32'h3FFF_FFFF, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    // Buffers ending inside the payload
    send_word(32'hC0FF_3FFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0002, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h5555_5555, 1'b1);
    // Lone filler buffer
    send_word(32'h8000_0000, 1'b1);
    // Unsupported header after a complete packet
    send_word(32'hC001_0000, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b0);
    send_word(32'h4000_0001, 1'b0);
    send_word(32'h5555_5555, 1'b1);

    // Random buffers, with one stretch free of gaps and stalls
    random_words = 0;
    while (random_words < RandomWords) begin
      steady = (random_words >= 500 && random_words < 800);
      build_buffer();
      send_burst();
      random_words += burst.size();
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain the remaining results
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d command words in %0d buffers; %0d framed results compared.",
             words_sent, buffers_sent, checked);
    $display("%0d words carried a truncation or unsupported-type status.", errored);
    if (fails == 0) begin
      $display("PASS command_packet_framer");
    end else begin
      $display("FAIL command_packet_framer");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #400000;
    $display("FAIL command_packet_framer");
    $finish;
  end

endmodule
